// ===== rtl/core/pdsw_pkg.sv =====
`timescale 1ns / 1ps
package pdsw_pkg;

	localparam int DEF_MAX_SENDERS = 16;
	localparam int DEF_WINDOW      = 64;

	localparam int BASE_W      = 64;
	localparam int SEQ_W       = 63;
	localparam int SID_W       = 8;
	localparam int CFG_W       = 5;
	localparam int LIMIT_W     = 9;
	localparam int IN_TDATA_W  = 80;
	localparam int OUT_TDATA_W = 8;

	localparam int IN_SP_BIT   = 0;
	localparam int IN_SID_LSB  = 1;
	localparam int IN_QP_BIT   = 9;
	localparam int IN_SEQ_LSB  = 10;

	localparam logic ACT_ARRIVE   = 1'b0;
	localparam logic ACT_COMPLETE = 1'b1;

	typedef enum logic [1:0] {
		ST_NEW     = 2'd0,
		ST_DONE    = 2'd1,
		ST_DUP     = 2'd2,
		ST_INVALID = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOAD,
		S_CHECK,
		S_EXEC,
		S_SLIDE,
		S_WRITE,
		S_DONE
	} state_t;

	typedef struct packed {
		logic accept;
		logic rd_en;
		logic load;
		logic check;
		logic exec;
		logic slide;
		logic write;
		logic out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic sender_ok;
		logic store;
		logic complete;
		logic slide_more;
		logic out_free;
	} dpath_sts_t;

endpackage

// ===== rtl/core/pdsw_ram.sv =====
`timescale 1ns / 1ps
module pdsw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                          wr_data,
	input  logic                                      rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                          rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/core/pdsw_ctrl.sv =====
`timescale 1ns / 1ps
module pdsw_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  pdsw_pkg::dpath_sts_t   sts,
	output pdsw_pkg::ctrl_cmd_t    cmd
);
	import pdsw_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = sts.sender_ok ? S_LOAD : S_DONE;
				end
			end
			S_LOAD:  state_d = S_CHECK;
			S_CHECK: state_d = S_EXEC;
			S_EXEC: begin
				if (sts.complete) begin
					state_d = S_SLIDE;
				end else if (sts.store) begin
					state_d = S_WRITE;
				end else begin
					state_d = S_DONE;
				end
			end
			S_SLIDE: begin
				if (!sts.slide_more) begin
					state_d = S_WRITE;
				end
			end
			S_WRITE: state_d = S_DONE;
			S_DONE: begin
				if (sts.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
				cmd.rd_en  = in_valid && sts.sender_ok;
			end
			S_LOAD:  cmd.load  = 1'b1;
			S_CHECK: cmd.check = 1'b1;
			S_EXEC:  cmd.exec  = 1'b1;
			S_SLIDE: cmd.slide = sts.slide_more;
			S_WRITE: cmd.write = 1'b1;
			S_DONE:  cmd.out_load = sts.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

// ===== rtl/core/pdsw_dpath.sv =====
`timescale 1ns / 1ps
module pdsw_dpath #(
	parameter int MAX_SENDERS = pdsw_pkg::DEF_MAX_SENDERS,
	parameter int WINDOW      = pdsw_pkg::DEF_WINDOW
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [pdsw_pkg::CFG_W-1:0]         cfg_wr_data,
	input  logic                               in_user,
	input  logic [pdsw_pkg::IN_TDATA_W-1:0]    in_data,
	input  logic                               in_last,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [pdsw_pkg::OUT_TDATA_W-1:0]   out_data,
	input  pdsw_pkg::ctrl_cmd_t                cmd,
	output pdsw_pkg::dpath_sts_t               sts
);
	import pdsw_pkg::*;

	localparam int SW = (MAX_SENDERS > 1) ? $clog2(MAX_SENDERS) : 1;
	localparam int IW = $clog2(WINDOW);
	localparam int CW = $clog2(WINDOW + 1);
	localparam int DW = BASE_W + 2 * WINDOW + CW;

	logic [CFG_W-1:0]       sender_count_q;
	logic [CFG_W-1:0]       remaining_q;
	logic [MAX_SENDERS-1:0] valid_q;
	logic                   out_valid_q;

	logic              act_q;
	logic              eos_q;
	logic [SEQ_W-1:0]  seq_q;
	logic [SW-1:0]     sidx_q;
	logic [BASE_W-1:0] wbase_q;
	logic [BASE_W-1:0] next_q;
	logic [BASE_W-1:0] off_q;
	logic              old_q;
	logic [WINDOW-1:0] wrm_q;
	logic [WINDOW-1:0] wcm_q;
	logic [CW-1:0]     wcnt_q;
	status_t           res_status_q;
	logic              res_close_q;
	status_t           out_status_q;
	logic              out_close_q;

	logic [SID_W-1:0]   in_sid;
	logic [LIMIT_W-1:0] limit;
	logic [DW-1:0]      rd_data;
	logic [DW-1:0]      wr_data;
	logic [BASE_W-1:0]  rd_base;
	logic [WINDOW-1:0]  rd_rm;
	logic [WINDOW-1:0]  rd_cm;
	logic [CW-1:0]      rd_cnt;
	logic               far;
	logic               inwin;
	logic [IW-1:0]      bidx;
	logic               rbit;
	logic               cbit;
	status_t            ex_status;
	logic               ex_store;
	logic               ex_complete;

	assign in_sid = in_data[IN_SID_LSB +: SID_W];
	assign limit  = (LIMIT_W'(sender_count_q) < LIMIT_W'(MAX_SENDERS)) ?
		LIMIT_W'(sender_count_q) : LIMIT_W'(MAX_SENDERS);

	assign sts.sender_ok = in_data[IN_SP_BIT] && !in_sid[SID_W-1] &&
		(LIMIT_W'(in_sid) < limit) && in_data[IN_QP_BIT];

	pdsw_ram #(
		.WIDTH(DW),
		.DEPTH(MAX_SENDERS)
	) u_state_ram (
		.clk     (clk),
		.wr_en   (cmd.write),
		.wr_addr (sidx_q),
		.wr_data (wr_data),
		.rd_en   (cmd.rd_en),
		.rd_addr (in_sid[SW-1:0]),
		.rd_data (rd_data)
	);

	assign wr_data = {wcnt_q, wcm_q, wrm_q, wbase_q};
	assign rd_base = rd_data[0 +: BASE_W];
	assign rd_rm   = rd_data[BASE_W +: WINDOW];
	assign rd_cm   = rd_data[BASE_W + WINDOW +: WINDOW];
	assign rd_cnt  = rd_data[BASE_W + 2 * WINDOW +: CW];

	always_comb begin
		far         = off_q >= BASE_W'(WINDOW);
		inwin       = !old_q && !far;
		bidx        = off_q[IW-1:0];
		rbit        = wrm_q[bidx];
		cbit        = wcm_q[bidx];
		ex_status   = ST_INVALID;
		ex_store    = 1'b0;
		ex_complete = 1'b0;
		if (act_q == ACT_ARRIVE) begin
			if (inwin && rbit) begin
				ex_status = (!cbit || eos_q) ? ST_DUP : ST_DONE;
			end else if (old_q) begin
				ex_status = ST_DONE;
			end else if (far) begin
				ex_status = ST_INVALID;
			end else begin
				ex_status = ST_NEW;
				ex_store  = 1'b1;
			end
		end else if (inwin && rbit) begin
			ex_status   = ST_NEW;
			ex_complete = 1'b1;
		end
	end

	assign sts.store      = ex_store;
	assign sts.complete   = ex_complete;
	assign sts.slide_more = (wcnt_q > CW'(WINDOW / 2)) && wcm_q[0];
	assign sts.out_free   = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sender_count_q <= CFG_W'(1);
			remaining_q    <= CFG_W'(1);
			valid_q        <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				sender_count_q <= cfg_wr_data;
				remaining_q    <= cfg_wr_data;
				valid_q        <= '0;
			end else begin
				if (cmd.exec && ex_store && eos_q && remaining_q != '0) begin
					remaining_q <= remaining_q - CFG_W'(1);
				end
				if (cmd.write) begin
					valid_q[sidx_q] <= 1'b1;
				end
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			act_q        <= in_user;
			eos_q        <= in_last;
			seq_q        <= in_data[IN_SEQ_LSB +: SEQ_W];
			sidx_q       <= in_sid[SW-1:0];
			res_status_q <= ST_INVALID;
			res_close_q  <= 1'b0;
		end
		if (cmd.load) begin
			if (valid_q[sidx_q]) begin
				wbase_q <= rd_base;
				next_q  <= rd_base + BASE_W'(1);
				wrm_q   <= rd_rm;
				wcm_q   <= rd_cm;
				wcnt_q  <= rd_cnt;
			end else begin
				wbase_q <= '1;
				next_q  <= '0;
				wrm_q   <= '0;
				wcm_q   <= '0;
				wcnt_q  <= '0;
			end
		end
		if (cmd.check) begin
			{old_q, off_q} <= {2'b00, seq_q} - {1'b0, next_q};
		end
		if (cmd.exec) begin
			res_status_q <= ex_status;
			res_close_q  <= ex_store && eos_q && (remaining_q == CFG_W'(1));
			if (ex_store) begin
				wrm_q[bidx] <= 1'b1;
			end
			if (ex_complete) begin
				wcm_q[bidx] <= 1'b1;
				wcnt_q      <= wcnt_q + CW'(!cbit);
			end
		end
		if (cmd.slide) begin
			wrm_q   <= wrm_q >> 1;
			wcm_q   <= wcm_q >> 1;
			wcnt_q  <= wcnt_q - CW'(1);
			wbase_q <= wbase_q + BASE_W'(1);
		end
		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_close_q  <= res_close_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = {(OUT_TDATA_W - 3)'(0), out_close_q, out_status_q};

endmodule

// ===== rtl/core/packet_dedup_sliding_window_core.sv =====
`timescale 1ns / 1ps
// Per-sender duplicate and replay filter for sequenced packets.
// Input stream s_axis: tuser is the action (0 arrival check, 1 completion), tlast is the
// end-of-stream flag, tdata carries sender and sequence. Output stream m_axis returns one
// status transaction per input transaction, in order.
// cfg_wr_en/cfg_wr_data write the sender count; a write reloads the remaining-sender count
// and clears every sender window at once. Write only while no transaction is in flight.
// A transaction with a missing or bad sender/sequence skips the RAM read and goes to the
// output register as invalid. A valid one gets a state RAM read, a sequence compare and
// the map update, plus a write-back for a new arrival or recorded completion (which may
// first slide the window, up to WINDOW/2 steps). One transaction is handled at a time;
// the next is accepted the cycle after the last result enters the output register.
// Reset returns all windows to base -1 with empty maps, sender count 1, no pending result.
// When m_axis_tready is low the result holds in the output register; one more transaction
// is worked off meanwhile and then waits until the register drains.
module packet_dedup_sliding_window_core #(
	parameter int MAX_SENDERS = pdsw_pkg::DEF_MAX_SENDERS,
	parameter int WINDOW      = pdsw_pkg::DEF_WINDOW
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [pdsw_pkg::CFG_W-1:0]        cfg_wr_data,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// sender_present, src_idx[7:0], seq_present, seq_num[62:0], zero fill
	input  logic [pdsw_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	// action
	input  logic                              s_axis_tuser,
	input  logic                              s_axis_tlast,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// status[1:0], chan_close, zero fill
	output logic [pdsw_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
	import pdsw_pkg::*;

	ctrl_cmd_t  cmd;
	dpath_sts_t sts;

	pdsw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pdsw_dpath #(
		.MAX_SENDERS(MAX_SENDERS),
		.WINDOW     (WINDOW)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_user     (s_axis_tuser),
		.in_data     (s_axis_tdata),
		.in_last     (s_axis_tlast),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_data    (m_axis_tdata),
		.cmd         (cmd),
		.sts         (sts)
	);

endmodule
